### rtl/segment_intersection_point_macros.svh
// Assertion helpers shared by the segment intersection RTL.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef SEGMENT_INTERSECTION_POINT_MACROS_SVH
`define SEGMENT_INTERSECTION_POINT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SIP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SIP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sip_pkg.sv
`default_nettype none

package sip_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_CROSS    = 2'd0,
    ST_NONE     = 2'd1,
    ST_PARALLEL = 2'd2
  } sip_status_t;

endpackage

`default_nettype wire

### rtl/sip_chan_if.sv
`default_nettype none

interface sip_in_if #(parameter int COORD_BITS = 16) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] a_start_x;
  logic signed [COORD_BITS-1:0] a_start_y;
  logic signed [COORD_BITS-1:0] a_end_x;
  logic signed [COORD_BITS-1:0] a_end_y;
  logic signed [COORD_BITS-1:0] b_start_x;
  logic signed [COORD_BITS-1:0] b_start_y;
  logic signed [COORD_BITS-1:0] b_end_x;
  logic signed [COORD_BITS-1:0] b_end_y;

  modport source (
    output valid, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y,
    input  ready
  );
  modport sink (
    input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y,
    output ready
  );
endinterface

interface sip_out_if #(parameter int COORD_BITS = 16) ();
  import sip_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  sip_status_t                  status;

  modport source (output valid, point_x, point_y, status, input ready);
  modport sink (input valid, point_x, point_y, status, output ready);
endinterface

`default_nettype wire

### rtl/sip_front.sv
`default_nettype none

module sip_front #(
  parameter int C = 16,
  parameter int W = 35
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  logic signed [C-1:0] x1,
  input  logic signed [C-1:0] y1,
  input  logic signed [C-1:0] x2,
  input  logic signed [C-1:0] y2,
  input  logic signed [C-1:0] x3,
  input  logic signed [C-1:0] y3,
  input  logic signed [C-1:0] x4,
  input  logic signed [C-1:0] y4,
  output logic                dn_valid,
  input  logic                dn_ready,
  output logic [W-1:0]        den_o,
  output logic [W-1:0]        num_o,
  output logic [C:0]          magx_o,
  output logic [C:0]          magy_o,
  output logic [4*C+3:0]      side_o
);
  import sip_pkg::*;

  localparam int D = C + 1;
  localparam int P = 2 * D;

  // Stage 1: coordinate differences.
  logic                v1_r;
  logic signed [D-1:0] dx12_r, dy12_r, dx34_r, dy34_r, dx13_r, dy13_r;
  logic signed [C-1:0] x1a_r, y1a_r, x2a_r, y2a_r;
  // Stage 2: products and direction of segment A.
  logic                v2_r;
  logic signed [P-1:0] pd1_r, pd2_r, pt1_r, pt2_r, pu1_r, pu2_r;
  logic signed [C-1:0] x1b_r, y1b_r, x2b_r, y2b_r;
  logic [D-1:0]        magx_r, magy_r;
  logic                negx_r, negy_r;
  // Stage 3: normalized determinant, numerator and classification.
  logic                v3_r;
  logic [W-1:0]        den_r, num_r;
  logic [D-1:0]        magx3_r, magy3_r;
  logic                negx3_r, negy3_r;
  logic signed [C-1:0] x1c_r, y1c_r, x2c_r, y2c_r;
  sip_status_t         st_r;

  logic rdy1, rdy2, rdy3;
  logic signed [D-1:0] dlx, dly;
  logic signed [P:0]   d_full, t_full, u_full;
  logic [W-1:0]        d_w, t_w, u_w, den_nxt, t_nxt, u_nxt;
  logic                neg, t_ok, u_ok;
  sip_status_t         st_nxt;

  assign rdy3     = !v3_r || dn_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;

  assign dlx = D'(x2a_r) - D'(x1a_r);
  assign dly = D'(y2a_r) - D'(y1a_r);

  always_comb begin
    d_full  = (P+1)'(pd1_r) - (P+1)'(pd2_r);
    t_full  = (P+1)'(pt1_r) - (P+1)'(pt2_r);
    u_full  = (P+1)'(pu1_r) - (P+1)'(pu2_r);
    d_w     = d_full[W-1:0];
    t_w     = t_full[W-1:0];
    u_w     = u_full[W-1:0];
    neg     = d_w[W-1];
    den_nxt = neg ? (W'(0) - d_w) : d_w;
    t_nxt   = neg ? (W'(0) - t_w) : t_w;
    u_nxt   = neg ? (W'(0) - u_w) : u_w;
    // Parameter strictly inside (0,1): positive and below the determinant.
    t_ok    = !t_nxt[W-1] && (|t_nxt) && (t_nxt < den_nxt);
    u_ok    = !u_nxt[W-1] && (|u_nxt) && (u_nxt < den_nxt);
    if (d_w == '0) begin
      st_nxt = ST_PARALLEL;
    end else if (t_ok && u_ok) begin
      st_nxt = ST_CROSS;
    end else begin
      st_nxt = ST_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= up_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      dx12_r <= D'(x1) - D'(x2);
      dy12_r <= D'(y1) - D'(y2);
      dx34_r <= D'(x3) - D'(x4);
      dy34_r <= D'(y3) - D'(y4);
      dx13_r <= D'(x1) - D'(x3);
      dy13_r <= D'(y1) - D'(y3);
      x1a_r  <= x1;
      y1a_r  <= y1;
      x2a_r  <= x2;
      y2a_r  <= y2;
    end
    if (rdy2 && v1_r) begin
      pd1_r  <= P'(dx12_r) * P'(dy34_r);
      pd2_r  <= P'(dy12_r) * P'(dx34_r);
      pt1_r  <= P'(dx13_r) * P'(dy34_r);
      pt2_r  <= P'(dy13_r) * P'(dx34_r);
      pu1_r  <= P'(dy12_r) * P'(dx13_r);
      pu2_r  <= P'(dx12_r) * P'(dy13_r);
      x1b_r  <= x1a_r;
      y1b_r  <= y1a_r;
      x2b_r  <= x2a_r;
      y2b_r  <= y2a_r;
      negx_r <= dlx[D-1];
      negy_r <= dly[D-1];
      magx_r <= dlx[D-1] ? (D'(0) - dlx) : dlx;
      magy_r <= dly[D-1] ? (D'(0) - dly) : dly;
    end
    if (rdy3 && v2_r) begin
      den_r   <= den_nxt;
      num_r   <= t_nxt;
      st_r    <= st_nxt;
      magx3_r <= magx_r;
      magy3_r <= magy_r;
      negx3_r <= negx_r;
      negy3_r <= negy_r;
      x1c_r   <= x1b_r;
      y1c_r   <= y1b_r;
      x2c_r   <= x2b_r;
      y2c_r   <= y2b_r;
    end
  end

  assign dn_valid = v3_r;
  assign den_o    = den_r;
  assign num_o    = num_r;
  assign magx_o   = magx3_r;
  assign magy_o   = magy3_r;
  assign side_o   = {x1c_r, y1c_r, x2c_r, y2c_r, negx3_r, negy3_r, st_r};

endmodule

`default_nettype wire

### rtl/sip_div_step.sv
`default_nettype none

module sip_div_step #(
  parameter int C       = 16,
  parameter int W       = 35,
  parameter int BIT_IDX = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  logic [W-1:0]   den_i,
  input  logic [W-1:0]   num_i,
  input  logic [C:0]     magx_i,
  input  logic [C:0]     magy_i,
  input  logic [W:0]     rx_i,
  input  logic [C:0]     qx_i,
  input  logic [W:0]     ry_i,
  input  logic [C:0]     qy_i,
  input  logic [4*C+3:0] side_i,
  output logic           dn_valid,
  input  logic           dn_ready,
  output logic [W-1:0]   den_o,
  output logic [W-1:0]   num_o,
  output logic [C:0]     magx_o,
  output logic [C:0]     magy_o,
  output logic [W:0]     rx_o,
  output logic [C:0]     qx_o,
  output logic [W:0]     ry_o,
  output logic [C:0]     qy_o,
  output logic [4*C+3:0] side_o
);

  // One step of floor(mag * num / den): shift in a zero, then add num if
  // the current magnitude bit is set, reducing modulo den after each part.
  function automatic logic [W+C+1:0] step(input logic [W:0] r, input logic [C:0] q,
                                          input logic b, input logic [W-1:0] dn,
                                          input logic [W-1:0] nm);
    logic [W:0] rr;
    logic [C:0] qq;
    rr = {r[W-1:0], 1'b0};
    qq = {q[C-1:0], 1'b0};
    if (rr >= (W+1)'(dn)) begin
      qq = qq + (C+1)'(1);
      rr = rr - (W+1)'(dn);
    end
    if (b) begin
      rr = rr + (W+1)'(nm);
      if (rr >= (W+1)'(dn)) begin
        qq = qq + (C+1)'(1);
        rr = rr - (W+1)'(dn);
      end
    end
    return {rr, qq};
  endfunction

  logic             v_r;
  logic [W+C+1:0]   sx, sy;

  assign up_ready = !v_r || dn_ready;
  assign sx = step(rx_i, qx_i, magx_i[BIT_IDX], den_i, num_i);
  assign sy = step(ry_i, qy_i, magy_i[BIT_IDX], den_i, num_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      den_o  <= den_i;
      num_o  <= num_i;
      magx_o <= magx_i;
      magy_o <= magy_i;
      rx_o   <= sx[W+C+1:C+1];
      qx_o   <= sx[C:0];
      ry_o   <= sy[W+C+1:C+1];
      qy_o   <= sy[C:0];
      side_o <= side_i;
    end
  end

  assign dn_valid = v_r;

endmodule

`default_nettype wire

### rtl/segment_intersection_point.sv
// Segment intersection engine.
// The in_ch channel carries one item per pair of segments: the start and end
// points of segment A and of segment B, signed fixed point of COORD_BITS
// bits (Q12.4 at the default). The out_ch channel returns one item per input
// item, in order: the crossing point and status ST_CROSS when both segment
// parameters lie strictly inside (0,1), otherwise A's end point with status
// ST_NONE, or ST_PARALLEL when the determinant is zero.
// Throughput is one item per cycle while out_ch.ready stays high. The
// pipeline is three front stages (differences, six parallel multipliers,
// determinant and classification), COORD_BITS + 1 divider stages that each
// retire one bit of the truncated quotient t * |delta| / det, and the output
// register that adds the quotient to the start point.
// Every stage has its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up and a stalled receiver holds the
// pipeline only as it fills; no item is lost or repeated.
// Synchronous reset clears every valid bit; no item is in flight afterwards
// and the block takes input in the first cycle after reset is released.
`default_nettype none
`include "segment_intersection_point_macros.svh"

module segment_intersection_point #(
  parameter int COORD_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  sip_in_if.sink    in_ch,
  sip_out_if.source out_ch
);
  import sip_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int D  = C + 1;
  // Cross products wrap to 64 bits for the widest coordinates.
  localparam int WF = 2 * C + 3;
  localparam int W  = (WF > 64) ? 64 : WF;
  localparam int N  = C + 1;          // divider stages
  localparam int SW = 4 * C + 4;

  // Link k feeds divider stage k; link N is the divider's output.
  logic          v   [N+1];
  logic          rdy [N+1];
  logic [W-1:0]  den [N+1];
  logic [W-1:0]  num [N+1];
  logic [C:0]    magx[N+1];
  logic [C:0]    magy[N+1];
  logic [W:0]    rx  [N+1];
  logic [C:0]    qx  [N+1];
  logic [W:0]    ry  [N+1];
  logic [C:0]    qy  [N+1];
  logic [SW-1:0] side[N+1];

  sip_front #(.C(C), .W(W)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_ch.valid),
    .up_ready (in_ch.ready),
    .x1       (in_ch.a_start_x),
    .y1       (in_ch.a_start_y),
    .x2       (in_ch.a_end_x),
    .y2       (in_ch.a_end_y),
    .x3       (in_ch.b_start_x),
    .y3       (in_ch.b_start_y),
    .x4       (in_ch.b_end_x),
    .y4       (in_ch.b_end_y),
    .dn_valid (v[0]),
    .dn_ready (rdy[0]),
    .den_o    (den[0]),
    .num_o    (num[0]),
    .magx_o   (magx[0]),
    .magy_o   (magy[0]),
    .side_o   (side[0])
  );

  // The remainder and quotient start at zero for every item.
  assign rx[0] = '0;
  assign qx[0] = '0;
  assign ry[0] = '0;
  assign qy[0] = '0;

  // Stage k handles magnitude bit C - k, most significant first.
  for (genvar k = 0; k < N; k++) begin : g_div
    sip_div_step #(.C(C), .W(W), .BIT_IDX(C - k)) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (v[k]),
      .up_ready (rdy[k]),
      .den_i    (den[k]),
      .num_i    (num[k]),
      .magx_i   (magx[k]),
      .magy_i   (magy[k]),
      .rx_i     (rx[k]),
      .qx_i     (qx[k]),
      .ry_i     (ry[k]),
      .qy_i     (qy[k]),
      .side_i   (side[k]),
      .dn_valid (v[k+1]),
      .dn_ready (rdy[k+1]),
      .den_o    (den[k+1]),
      .num_o    (num[k+1]),
      .magx_o   (magx[k+1]),
      .magy_o   (magy[k+1]),
      .rx_o     (rx[k+1]),
      .qx_o     (qx[k+1]),
      .ry_o     (ry[k+1]),
      .qy_o     (qy[k+1]),
      .side_o   (side[k+1])
    );
  end

  // Unpack the side band that rode along with the divider.
  logic signed [C-1:0] t_x1, t_y1, t_x2, t_y2;
  logic                t_negx, t_negy;
  sip_status_t         t_st;
  logic signed [D-1:0] sum_x, sum_y;

  assign {t_x1, t_y1, t_x2, t_y2, t_negx, t_negy, t_st} = side[N];

  assign sum_x = t_negx ? (D'(t_x1) - $signed(qx[N])) : (D'(t_x1) + $signed(qx[N]));
  assign sum_y = t_negy ? (D'(t_y1) - $signed(qy[N])) : (D'(t_y1) + $signed(qy[N]));

  // Output register.
  logic                out_v_r;
  logic signed [C-1:0] px_r, py_r;
  sip_status_t         st_r;

  assign rdy[N] = !out_v_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (rdy[N]) begin
      out_v_r <= v[N];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[N] && v[N]) begin
      st_r <= t_st;
      if (t_st == ST_CROSS) begin
        px_r <= sum_x[C-1:0];
        py_r <= sum_y[C-1:0];
      end else begin
        px_r <= t_x2;
        py_r <= t_y2;
      end
    end
  end

  assign out_ch.valid   = out_v_r;
  assign out_ch.point_x = px_r;
  assign out_ch.point_y = py_r;
  assign out_ch.status  = st_r;

  `SIP_ASSERT_NEXT(a_front_hold, v[0] && !rdy[0], v[0] && $stable(num[0]), "front output changed while stalled")
  `SIP_ASSERT_NEXT(a_div_hold, v[N] && !rdy[N], v[N] && $stable(qx[N]), "divider output changed while stalled")
  `SIP_ASSERT_SAME(a_rem_bound, v[N] && t_st == ST_CROSS, rx[N] < (W+1)'(den[N]), "divider remainder not below determinant")

endmodule

`default_nettype wire
